// ----- sv/modexp_pkg.sv -----
package modexp_pkg;
  localparam int OPERAND_WIDTH_DEF = 32;

  typedef struct packed {
    logic load;
    logic mul_start;
    logic mul_sel_acc;
    logic red_start;
  } modexp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic exp_zero;
    logic exp_lsb;
  } modexp_sts_t;
endpackage

// ----- sv/modexp_datapath.sv -----
module modexp_datapath
  import modexp_pkg::*;
#(
  parameter int OperandWidth = OPERAND_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  modexp_cmd_t             cmd,
  output modexp_sts_t             sts,
  input  logic [OperandWidth-1:0] base_i,
  input  logic [OperandWidth-1:0] exp_i,
  input  logic [OperandWidth-1:0] mod_i,
  output logic [OperandWidth-2:0] acc_o
);
  localparam int VW = OperandWidth - 1;
  localparam int CW = $clog2(OperandWidth + 1);

  logic [VW-1:0] m_r, acc_r, sq_r, e_r;
  logic [VW-1:0] ma_r, mb_r, mp_r;
  logic [VW:0]   ma2, mp_sum;
  logic [VW-1:0] ma_nxt, mp_nxt;
  logic [CW-1:0] cnt_r;
  logic          busy_r, red_r, sel_r, done_r;

  // shift-and-add modular multiply; the base is reduced first by a separate
  // bit-serial remainder: a % m computed as a*1 mod m needs a<m, so reduce
  // by restoring division instead (red mode): rem = rem*2 + bit, minus m
  assign ma2    = {ma_r, 1'b0};
  assign ma_nxt = (ma2 >= {1'b0, m_r}) ? VW'(ma2 - {1'b0, m_r}) : ma_r << 1;
  assign mp_sum = {1'b0, mp_r} + {1'b0, ma_r};
  assign mp_nxt = (mp_sum >= {1'b0, m_r}) ? VW'(mp_sum - {1'b0, m_r}) : mp_r + ma_r;

  logic [VW:0] rs;
  assign rs = {mp_r, mb_r[VW-1]};

  // one-cycle pulse after the last step of a multiply or remainder
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && !cmd.load && !cmd.red_start && !cmd.mul_start &&
                (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (cmd.load) begin
      m_r   <= mod_i[VW-1:0];
      e_r   <= exp_i[VW-1:0];
      acc_r <= VW'(1);
      sq_r  <= base_i[VW-1:0];
    end else if (cmd.red_start) begin
      busy_r <= 1'b1; red_r <= 1'b1;
      mp_r <= '0; mb_r <= sq_r; cnt_r <= CW'(VW);
    end else if (cmd.mul_start) begin
      busy_r <= 1'b1; red_r <= 1'b0; sel_r <= cmd.mul_sel_acc;
      mp_r <= '0; ma_r <= sq_r; mb_r <= cmd.mul_sel_acc ? acc_r : sq_r;
      cnt_r <= CW'(VW);
    end else if (busy_r) begin
      if (red_r) begin
        mp_r <= (rs >= {1'b0, m_r}) ? VW'(rs - {1'b0, m_r}) : VW'(rs);
        mb_r <= mb_r << 1;
      end else begin
        if (mb_r[0]) mp_r <= mp_nxt;
        ma_r <= ma_nxt;
        mb_r <= mb_r >> 1;
      end
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end else if (done_r) begin
      if (red_r) sq_r <= mp_r;
      else if (sel_r) acc_r <= mp_r;
      else begin
        sq_r <= mp_r;
        e_r  <= e_r >> 1;
      end
    end
  end

  assign sts.mul_done = done_r;
  assign sts.exp_zero = (e_r == '0);
  assign sts.exp_lsb  = e_r[0];
  assign acc_o        = acc_r;
endmodule

// ----- sv/modexp_ctrl.sv -----
module modexp_ctrl
  import modexp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        fast,
  output logic        busy,
  output logic        finish,
  input  modexp_sts_t sts,
  output modexp_cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0, S_RED = 3'd1, S_RWAIT = 3'd2, S_TEST = 3'd3,
                         S_MWAIT = 3'd4, S_SQ = 3'd5, S_SWAIT = 3'd6, S_FIN = 3'd7;
  logic [2:0] st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    cmd = '0;
    finish = 1'b0;
    case (st_r)
      S_IDLE: if (start) begin
        cmd.load = 1'b1;
        st_nxt = fast ? S_FIN : S_RED;
      end
      S_RED: begin cmd.red_start = 1'b1; st_nxt = S_RWAIT; end
      S_RWAIT: if (sts.mul_done) st_nxt = S_TEST;
      S_TEST: begin
        if (sts.exp_zero) st_nxt = S_FIN;
        else if (sts.exp_lsb) begin
          cmd.mul_start = 1'b1; cmd.mul_sel_acc = 1'b1; st_nxt = S_MWAIT;
        end else st_nxt = S_SQ;
      end
      S_MWAIT: if (sts.mul_done) st_nxt = S_SQ;
      S_SQ: begin cmd.mul_start = 1'b1; st_nxt = S_SWAIT; end
      S_SWAIT: if (sts.mul_done) st_nxt = S_TEST;
      S_FIN: begin finish = 1'b1; st_nxt = S_IDLE; end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign busy = (st_r != S_IDLE);
endmodule

// ----- sv/modular_exponentiation.sv -----
// Modular exponentiation x^y mod z, right-to-left square-and-multiply. One
// operand transfer gives one result transfer. The base is first reduced by a
// bit-serial restoring remainder, then each exponent bit costs a squaring
// plus, when set, a multiply into the accumulator, all in the shared
// shift-and-add unit. Negative operands, zero exponent and modulus of 0 or
// 1 skip the unit; negative operands and a zero modulus with a nonzero
// exponent give out_valid_res low and a zero result, the rest a valid one.
// One item at a time: the input is ready again the cycle after the result
// transfer.
module modular_exponentiation
  import modexp_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OPERAND_WIDTH-1:0] in_base,
  input  logic [OPERAND_WIDTH-1:0] in_exponent,
  input  logic [OPERAND_WIDTH-1:0] in_modulus,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [30:0]              out_power_mod,
  output logic                     out_valid_res
);
  localparam int W = OPERAND_WIDTH;
  modexp_cmd_t cmd;
  modexp_sts_t sts;
  logic busy, finish, fast, start;
  logic [W-2:0] acc;
  logic sp_r, sv_r;          // special-case outcome captured at the transfer
  logic sp_nxt, sv_nxt, sres_nxt, sres_r;
  logic neg, y0, z0, z1;

  assign neg = in_base[W-1] | in_exponent[W-1] | in_modulus[W-1];
  assign y0  = (in_exponent == '0);
  assign z0  = (in_modulus == '0);
  assign z1  = (in_modulus == W'(1));
  always_comb begin
    sp_nxt = neg | y0 | z0 | z1;
    sv_nxt = !(neg | (!y0 & z0));
    sres_nxt = !neg & y0 & !z0 & !z1;
  end
  assign fast = sp_nxt;

  // accept only when idle and the result register is free
  assign in_ready = !busy && !out_valid;
  assign start = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (start) begin
      sp_r <= sp_nxt; sv_r <= sv_nxt; sres_r <= sres_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (finish) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_valid_res <= sp_r ? sv_r : 1'b1;
      out_power_mod <= sp_r ? {30'd0, sres_r} : 31'(acc);
    end
  end

  modexp_ctrl u_ctrl (
    .clk, .rst_n, .start, .fast, .busy, .finish, .sts, .cmd
  );

  modexp_datapath #(.OperandWidth(W)) u_dp (
    .clk, .rst_n, .cmd, .sts,
    .base_i(in_base), .exp_i(in_exponent), .mod_i(in_modulus), .acc_o(acc)
  );
endmodule

// ----- sv/modexp_checker.sv -----
module modexp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [30:0] out_power_mod,
  input logic out_valid_res
);
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_power_mod))
    else $error("result changed under stall");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("accepting while result pending");
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_valid_res |-> out_power_mod == 31'd0)
    else $error("invalid result not zero");
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result too early");
endmodule

bind modular_exponentiation modexp_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_power_mod, .out_valid_res
);
